/* sv/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types, codes and sizes of the keyed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 3;
   localparam int POS_W     = 4;
   localparam int COUNT_W   = 5;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 80;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

   localparam int RSP_STATUS_LSB  = 0;
   localparam int RSP_POS_LSB     = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_DATA_LSB    = RSP_POS_LSB + POS_W;
   localparam int RSP_COUNT_LSB   = RSP_DATA_LSB + PAYLOAD_W;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

endpackage

`default_nettype wire

/* sv/krt_mem.sv */
// ----------------------------------------------------------------------------
// krt_mem
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_mem #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [IW-1:0]       wr_addr,
   input  wire krt_pkg::entry_type  wr_entry,
   input  wire logic [IW-1:0]       rd_addr,
   output      krt_pkg::entry_type  rd_entry
);

   krt_pkg::entry_type mem [TABLE_DEPTH];
   krt_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

/* sv/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table
// Table of keyed records in insertion order with insert, update, delete and
// lookup, each preceded by a linear key search; key zero is rejected.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request runs from its transfer to its
// result through a key search (one record memory read per valid entry up to
// a hit), then compare, act and output; key zero skips the search. A delete
// that hits the last entry just drops it; any other delete that hits moves
// each later entry down one place, one at a time, since the shift runs
// through the one read port and one write port of the record memory. A new
// request is taken while the previous result still waits on the output.
`default_nettype none

module keyed_record_table #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [31:0] key, [95:32] payload
   input  wire logic [krt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  wire logic [krt_pkg::CMD_W-1:0]       req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [2:0] status, [6:3] position, [70:7] data_out, [75:71] entry_count
   output      logic [krt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;
   localparam logic [2:0] S_ACT   = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [krt_pkg::CMD_W-1:0]           cmd_ff, cmd_in;
   logic [krt_pkg::KEY_W-1:0]           key_ff, key_in;
   logic [krt_pkg::PAYLOAD_W-1:0]       pay_ff, pay_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       scan_ff, scan_in;
   logic                                chk_ff, chk_in;
   logic                                hit_ff, hit_in;
   logic [IW-1:0]                       hpos_ff, hpos_in;
   logic [krt_pkg::STATUS_W-1:0]        st_ff, st_in;
   logic [IW-1:0]                       rpos_ff, rpos_in;
   logic [krt_pkg::PAYLOAD_W-1:0]       rdat_ff, rdat_in;
   logic [CW-1:0]                       sh_ff, sh_in;
   logic                                pend_ff, pend_in;
   logic [IW-1:0]                       wptr_ff, wptr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [krt_pkg::RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [CW-1:0]                       scan_dec;
   logic [CW:0]                         sh_next;
   logic                                wr_en;
   logic [IW-1:0]                       wr_addr;
   krt_pkg::entry_type                  wr_entry;
   logic [IW-1:0]                       rd_addr;
   krt_pkg::entry_type                  rd_entry;

   krt_mem #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IW          (IW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   assign scan_dec = scan_ff - CW'(1);
   assign sh_next  = {1'b0, sh_ff} + (CW+1)'(1);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      chk_in       = 1'b0;
      hit_in       = hit_ff;
      hpos_in      = hpos_ff;
      st_in        = st_ff;
      rpos_in      = rpos_ff;
      rdat_in      = rdat_ff;
      sh_in        = sh_ff;
      pend_in      = 1'b0;
      wptr_in      = wptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = wptr_ff;
      wr_entry     = rd_entry;
      rd_addr      = scan_ff[IW-1:0];
      req_tready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               key_in  = req_tdata[krt_pkg::KEY_W-1:0];
               pay_in  = req_tdata[krt_pkg::KEY_W +: krt_pkg::PAYLOAD_W];
               scan_in = '0;
               hit_in  = 1'b0;
               if (req_tdata[krt_pkg::KEY_W-1:0] == '0) begin
                  st_in    = krt_pkg::ST_INVALID;
                  rpos_in  = '0;
                  rdat_in  = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (chk_ff && rd_entry.key == key_ff) begin
               hit_in   = 1'b1;
               hpos_in  = scan_dec[IW-1:0];
               rdat_in  = rd_entry.payload;
               state_in = S_ACT;
            end else if (scan_ff >= count_ff) begin
               hit_in   = 1'b0;
               state_in = S_ACT;
            end else begin
               rd_addr = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
               chk_in  = 1'b1;
            end
         end
         S_ACT: begin
            st_in    = krt_pkg::ST_OK;
            rpos_in  = hpos_ff;
            state_in = S_DONE;
            unique case (cmd_ff)
               krt_pkg::CMD_INSERT: begin
                  rdat_in = '0;
                  if (hit_ff) begin
                     st_in = krt_pkg::ST_DUPLICATE;
                  end else if (count_ff >= CW'(TABLE_DEPTH)) begin
                     st_in   = krt_pkg::ST_FULL;
                     rpos_in = '0;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = count_ff[IW-1:0];
                     wr_entry.key     = key_ff;
                     wr_entry.payload = pay_ff;
                     count_in         = count_ff + CW'(1);
                     rpos_in          = count_ff[IW-1:0];
                  end
               end
               krt_pkg::CMD_UPDATE: begin
                  rdat_in = '0;
                  if (hit_ff) begin
                     wr_en            = 1'b1;
                     wr_addr          = hpos_ff;
                     wr_entry.key     = key_ff;
                     wr_entry.payload = pay_ff;
                  end else begin
                     st_in   = krt_pkg::ST_NOT_FOUND;
                     rpos_in = '0;
                  end
               end
               krt_pkg::CMD_DELETE: begin
                  rdat_in = '0;
                  if (hit_ff) begin
                     sh_in    = CW'(hpos_ff);
                     state_in = S_SHIFT;
                  end else begin
                     st_in   = krt_pkg::ST_NOT_FOUND;
                     rpos_in = '0;
                  end
               end
               krt_pkg::CMD_LOOKUP: begin
                  if (!hit_ff) begin
                     st_in   = krt_pkg::ST_NOT_FOUND;
                     rpos_in = '0;
                     rdat_in = '0;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            // move entry sh+1 down to sh; the write lands in the cycle after its read
            if (pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = wptr_ff;
               wr_entry = rd_entry;
            end
            if (sh_next < {1'b0, count_ff}) begin
               rd_addr = sh_next[IW-1:0];
               pend_in = 1'b1;
               wptr_in = sh_ff[IW-1:0];
               sh_in   = sh_next[CW-1:0];
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[krt_pkg::RSP_STATUS_LSB +: krt_pkg::STATUS_W] = st_ff;
               rsp_data_in[krt_pkg::RSP_POS_LSB +: krt_pkg::POS_W] =
                  krt_pkg::POS_W'(rpos_ff);
               rsp_data_in[krt_pkg::RSP_DATA_LSB +: krt_pkg::PAYLOAD_W] = rdat_ff;
               rsp_data_in[krt_pkg::RSP_COUNT_LSB +: krt_pkg::COUNT_W] =
                  krt_pkg::COUNT_W'(count_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      hpos_ff     <= hpos_in;
      st_ff       <= st_in;
      rpos_ff     <= rpos_in;
      rdat_ff     <= rdat_in;
      sh_ff       <= sh_in;
      wptr_ff     <= wptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* sv/krt_checker.sv */
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks of the keyed record table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_checker #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEFAULT
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [krt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic [krt_pkg::CMD_W-1:0]       req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [krt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic [krt_pkg::STATUS_W-1:0]  rsp_status;
   logic [krt_pkg::POS_W-1:0]     rsp_pos;
   logic [krt_pkg::PAYLOAD_W-1:0] rsp_dout;
   logic [krt_pkg::COUNT_W-1:0]   rsp_count;
   logic                          req_seen;

   assign rsp_status = rsp_tdata[krt_pkg::RSP_STATUS_LSB +: krt_pkg::STATUS_W];
   assign rsp_pos    = rsp_tdata[krt_pkg::RSP_POS_LSB +: krt_pkg::POS_W];
   assign rsp_dout   = rsp_tdata[krt_pkg::RSP_DATA_LSB +: krt_pkg::PAYLOAD_W];
   assign rsp_count  = rsp_tdata[krt_pkg::RSP_COUNT_LSB +: krt_pkg::COUNT_W];
   assign req_seen   = req_tvalid && req_tready && (req_tuser == req_tuser)
                       && (req_tdata == req_tdata);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_status_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status <= krt_pkg::ST_INVALID)
      else $error("status code out of range");

   a_fail_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != krt_pkg::ST_OK |-> rsp_dout == '0)
      else $error("failed request returned data");

   a_invalid_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == krt_pkg::ST_INVALID |-> rsp_pos == '0)
      else $error("invalid key reported a position");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == krt_pkg::ST_FULL
      |-> rsp_count == krt_pkg::COUNT_W'(TABLE_DEPTH) && !(req_seen && !req_tready))
      else $error("table full reported below depth");

endmodule

bind keyed_record_table krt_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_krt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/sv/keyed_record_table_checker.sv */
// ----------------------------------------------------------------------------
// keyed_record_table_checker
// Watches both stream channels of the keyed record table. It keeps its own
// copy of the records, works out the result of every request transfer and
// compares each response transfer, field by field, with the oldest result
// still owed. It reports the number of failures and of results still owed.
// ----------------------------------------------------------------------------
module keyed_record_table_checker #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [31:0] key, [95:32] payload
   input  logic [krt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [krt_pkg::CMD_W-1:0]      req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] status, [6:3] position, [70:7] data_out, [75:71] entry_count
   input  logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             failure_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [krt_pkg::STATUS_W-1:0]  status;
      logic [krt_pkg::POS_W-1:0]     position;
      logic [krt_pkg::PAYLOAD_W-1:0] data_out;
      logic [krt_pkg::COUNT_W-1:0]   entry_count;
   } record_result_type;

   logic [krt_pkg::KEY_W-1:0]     key_mem [TABLE_DEPTH];
   logic [krt_pkg::PAYLOAD_W-1:0] payload_mem [TABLE_DEPTH];
   int                            fill_level;
   record_result_type             owed_results [$];

   initial begin
      failure_count = 0;
      pending_count = 0;
      fill_level = 0;
   end

   function automatic record_result_type apply_request(
      logic [krt_pkg::CMD_W-1:0]     command,
      logic [krt_pkg::KEY_W-1:0]     key,
      logic [krt_pkg::PAYLOAD_W-1:0] payload);
      record_result_type res;
      int                hit_index;
      res = '0;
      hit_index = -1;
      if (key == '0) begin
         res.status = krt_pkg::ST_INVALID;
      end else begin
         for (int i = 0; i < fill_level; i++) begin
            if (hit_index < 0 && key_mem[i] == key) begin
               hit_index = i;
            end
         end
         res.status = krt_pkg::ST_OK;
         if (hit_index >= 0) begin
            res.position = krt_pkg::POS_W'(hit_index);
         end
         case (command)
            krt_pkg::CMD_INSERT: begin
               if (hit_index >= 0) begin
                  res.status = krt_pkg::ST_DUPLICATE;
               end else if (fill_level >= TABLE_DEPTH) begin
                  res.status = krt_pkg::ST_FULL;
               end else begin
                  res.position = krt_pkg::POS_W'(fill_level);
                  key_mem[fill_level] = key;
                  payload_mem[fill_level] = payload;
                  fill_level++;
               end
            end
            krt_pkg::CMD_UPDATE: begin
               if (hit_index >= 0) begin
                  payload_mem[hit_index] = payload;
               end else begin
                  res.status = krt_pkg::ST_NOT_FOUND;
               end
            end
            krt_pkg::CMD_DELETE: begin
               if (hit_index >= 0) begin
                  for (int i = hit_index; i + 1 < fill_level; i++) begin
                     key_mem[i] = key_mem[i + 1];
                     payload_mem[i] = payload_mem[i + 1];
                  end
                  fill_level--;
               end else begin
                  res.status = krt_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               if (hit_index >= 0) begin
                  res.data_out = payload_mem[hit_index];
               end else begin
                  res.status = krt_pkg::ST_NOT_FOUND;
               end
            end
         endcase
      end
      res.entry_count = krt_pkg::COUNT_W'(fill_level);
      return res;
   endfunction

   function automatic int field_differs(string name, logic [krt_pkg::PAYLOAD_W-1:0] want,
                                        logic [krt_pkg::PAYLOAD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      record_result_type want;
      record_result_type got;
      int                fresh;
      fresh = 0;
      if (reset) begin
         fill_level = 0;
         owed_results.delete();
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tdata[krt_pkg::RSP_STATUS_LSB +: krt_pkg::STATUS_W];
            got.position    = rsp_tdata[krt_pkg::RSP_POS_LSB +: krt_pkg::POS_W];
            got.data_out    = rsp_tdata[krt_pkg::RSP_DATA_LSB +: krt_pkg::PAYLOAD_W];
            got.entry_count = rsp_tdata[krt_pkg::RSP_COUNT_LSB +: krt_pkg::COUNT_W];
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               fresh++;
            end else begin
               want = owed_results.pop_front();
               fresh += field_differs("status", want.status, got.status);
               fresh += field_differs("position", want.position, got.position);
               fresh += field_differs("data_out", want.data_out, got.data_out);
               fresh += field_differs("entry_count", want.entry_count, got.entry_count);
            end
         end
         if (req_tvalid && req_tready) begin
            owed_results.push_back(apply_request(req_tuser,
                                                 req_tdata[krt_pkg::KEY_W-1:0],
                                                 req_tdata[krt_pkg::KEY_W +:
                                                           krt_pkg::PAYLOAD_W]));
         end
         failure_count <= failure_count + fresh;
         pending_count <= owed_results.size();
      end
   end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the keyed record table with a directed run over the key and payload
// extremes and every status code, then with random request mixes that
// fill, churn and drain the table, under random idling on both channels.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1650;
   localparam int KEY_POOL     = 28;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} request_mix_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [krt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [krt_pkg::CMD_W-1:0]      req_tuser = krt_pkg::CMD_LOOKUP;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                             failure_count;
   int                             pending_count;
   bit                             no_idle = 1'b0;
   logic [krt_pkg::KEY_W-1:0]      key_pool [KEY_POOL];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   keyed_record_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   keyed_record_table_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .failure_count (failure_count),
      .pending_count (pending_count)
   );

   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 23);
   end

   task automatic send_request(logic [krt_pkg::CMD_W-1:0] command,
                               logic [krt_pkg::KEY_W-1:0] key,
                               logic [krt_pkg::PAYLOAD_W-1:0] payload);
      if (!no_idle) begin
         while ($urandom_range(99) < 23) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= command;
      req_tdata  <= {payload, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [krt_pkg::KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 82) return key_pool[$urandom_range(KEY_POOL - 1)];
      if (roll < 92) return $urandom;
      if (roll < 96) return '0;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      request_mix_type           mix;
      int                        roll;
      logic [krt_pkg::CMD_W-1:0] command;
      mix = MIX_EVEN;
      for (int i = 0; i < KEY_POOL; i++) begin
         key_pool[i] = $urandom | 32'h1;
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0001;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(krt_pkg::CMD_LOOKUP, 32'h0000_0001, '0);
      send_request(krt_pkg::CMD_INSERT, '0, '1);
      send_request(krt_pkg::CMD_INSERT, 32'h8000_0000, '1);
      send_request(krt_pkg::CMD_INSERT, 32'h7FFF_FFFF, '0);
      send_request(krt_pkg::CMD_INSERT, 32'h8000_0000, 64'h5555_5555_5555_5555);
      send_request(krt_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(krt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, '0);
      send_request(krt_pkg::CMD_DELETE, 32'h8000_0000, '0);
      send_request(krt_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, '0);
      send_request(krt_pkg::CMD_UPDATE, 32'hFFFF_FFFF, '1);
      for (int i = 0; i < 15; i++) begin
         send_request(krt_pkg::CMD_INSERT, 32'h1 << i, {$urandom, $urandom});
      end
      send_request(krt_pkg::CMD_INSERT, 32'hFFFF_FFFF, '1);
      send_request(krt_pkg::CMD_DELETE, 32'h0000_4000, '0);
      send_request(krt_pkg::CMD_LOOKUP, '0, '1);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) mix = request_mix_type'($urandom_range(2));
         if (n == 600) no_idle = 1'b1;
         if (n == 800) no_idle = 1'b0;
         if (n % 250 == 249) drain_results();
         roll = $urandom_range(99);
         case (mix)
            MIX_FILL:
               command = roll < 55 ? krt_pkg::CMD_INSERT :
                         roll < 70 ? krt_pkg::CMD_UPDATE :
                         roll < 80 ? krt_pkg::CMD_DELETE : krt_pkg::CMD_LOOKUP;
            MIX_DRAIN:
               command = roll < 15 ? krt_pkg::CMD_INSERT :
                         roll < 30 ? krt_pkg::CMD_UPDATE :
                         roll < 70 ? krt_pkg::CMD_DELETE : krt_pkg::CMD_LOOKUP;
            default:
               command = krt_pkg::CMD_W'($urandom_range(3));
         endcase
         send_request(command, pick_key(), {$urandom, $urandom});
      end

      drain_results();
      repeat (40) @(negedge clock);
      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/krt_pkg.sv
sv/krt_mem.sv
sv/keyed_record_table.sv
sv/krt_checker.sv
tb/sv/keyed_record_table_checker.sv
tb/sv/testbench.sv
